/* hdl/ebalu_pkg.sv */
// Package for the 8-bit CPU ALU with flags: operation codes and field widths.
// No dependencies; used by eight_bit_cpu_alu_with_flags_core.
package ebalu_pkg;

  localparam int unsigned OpW   = 5;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned BitW  = 3;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_XOR   = 5'd5,
    OP_OR    = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_SWAP  = 5'd10,
    OP_SLA   = 5'd11,
    OP_SRA   = 5'd12,
    OP_SRL   = 5'd13,
    OP_RLC   = 5'd14,
    OP_RL    = 5'd15,
    OP_RRC   = 5'd16,
    OP_RR    = 5'd17,
    OP_BIT   = 5'd18,
    OP_SET   = 5'd19,
    OP_RES   = 5'd20,
    OP_ADD16 = 5'd21,
    OP_ADDSP = 5'd22
  } op_e;

  // Flag group carried from the ALU logic to the result register
  typedef struct packed {
    logic z;
    logic n;
    logic h;
    logic c;
  } flags_t;

endpackage

/* hdl/eight_bit_cpu_alu_with_flags_core.sv */
// Top level of the 8-bit CPU ALU with Z/N/H/C flags.
// Depends on ebalu_pkg for operation codes, widths and the flag struct.

// The ALU takes one transaction per clock: busy_o stays low, and a transaction
// accepted at an edge with start_i high goes through the input register and
// then the result register, which shows it for exactly one cycle with done_o
// high. The input and result registers sit around the single pass of adder,
// shifter and flag logic; throughput is one transaction per cycle.
// The receiver cannot stall the result, so it must take it in that cycle.
module eight_bit_cpu_alu_with_flags_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [ebalu_pkg::OpW-1:0]       operation_i,
  input  logic [ebalu_pkg::WordW-1:0]     operand_a_i,
  input  logic [ebalu_pkg::WordW-1:0]     operand_b_i,
  input  logic [ebalu_pkg::BitW-1:0]      bit_index_i,
  input  logic                            zero_in_i,
  input  logic                            subtract_in_i,
  input  logic                            half_in_i,
  input  logic                            carry_in_i,
  output logic                            done_o,
  output logic [ebalu_pkg::WordW-1:0]     result_value_o,
  output logic                            zero_out_o,
  output logic                            subtract_out_o,
  output logic                            half_out_o,
  output logic                            carry_out_o
);

  logic                            in_vld_q;
  logic [ebalu_pkg::OpW-1:0]       op_q;
  logic [ebalu_pkg::WordW-1:0]     a_q;
  logic [ebalu_pkg::WordW-1:0]     b_q;
  logic [ebalu_pkg::BitW-1:0]      bi_q;
  ebalu_pkg::flags_t               fin_q;

  logic                            done_q;
  logic [ebalu_pkg::WordW-1:0]     res_q;
  logic [ebalu_pkg::WordW-1:0]     res_d;
  ebalu_pkg::flags_t               fout_q;
  ebalu_pkg::flags_t               fout_d;

  logic                            accept;
  logic [ebalu_pkg::ByteW-1:0]     a8;
  logic [ebalu_pkg::ByteW-1:0]     b8;
  logic [ebalu_pkg::ByteW-1:0]     r8;
  logic [ebalu_pkg::ByteW-1:0]     bit_mask;
  logic                            cy;
  logic [ebalu_pkg::ByteW:0]       sum9;
  logic [ebalu_pkg::ByteW:0]       diff9;
  logic [4:0]                      nib_sum;
  logic [4:0]                      nib_diff;
  logic [ebalu_pkg::WordW:0]       sum17;
  logic [12:0]                     sum13;
  logic [ebalu_pkg::WordW-1:0]     sp_sum;
  logic [ebalu_pkg::ByteW:0]       sp_low9;
  logic [4:0]                      sp_nib;

  // Never stall the sender
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Input register: valid resets, payload just loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      a_q      <= operand_a_i;
      b_q      <= operand_b_i;
      bi_q     <= bit_index_i;
      fin_q.z  <= zero_in_i;
      fin_q.n  <= subtract_in_i;
      fin_q.h  <= half_in_i;
      fin_q.c  <= carry_in_i;
    end
  end

  // Shared datapath pieces
  assign a8       = a_q[ebalu_pkg::ByteW-1:0];
  assign b8       = b_q[ebalu_pkg::ByteW-1:0];
  assign cy       = ((op_q == ebalu_pkg::OP_ADC) || (op_q == ebalu_pkg::OP_SBC)) && fin_q.c;
  assign sum9     = {1'b0, a8} + {1'b0, b8} + {8'd0, cy};
  assign nib_sum  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cy};
  assign diff9    = {1'b0, a8} - {1'b0, b8} - {8'd0, cy};
  assign nib_diff = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cy};
  assign sum17    = {1'b0, a_q} + {1'b0, b_q};
  assign sum13    = {1'b0, a_q[11:0]} + {1'b0, b_q[11:0]};
  assign sp_sum   = a_q + {{(ebalu_pkg::WordW-ebalu_pkg::ByteW){b8[7]}}, b8};
  assign sp_low9  = {1'b0, a8} + {1'b0, b8};
  assign sp_nib   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]};
  assign bit_mask = ebalu_pkg::ByteW'(1) << bi_q;

  // Select result and flags per operation
  always_comb begin
    r8     = '0;
    res_d  = a_q;
    fout_d = fin_q;
    unique case (ebalu_pkg::op_e'(op_q))
      ebalu_pkg::OP_ADD, ebalu_pkg::OP_ADC: begin
        r8     = sum9[7:0];
        res_d  = {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b0, h: nib_sum[4], c: sum9[8]};
      end
      ebalu_pkg::OP_SUB, ebalu_pkg::OP_SBC, ebalu_pkg::OP_CP: begin
        r8     = diff9[7:0];
        res_d  = (op_q == ebalu_pkg::OP_CP) ? a_q : {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b1, h: nib_diff[4], c: diff9[8]};
      end
      ebalu_pkg::OP_AND: begin
        r8     = a8 & b8;
        res_d  = {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b0, h: 1'b1, c: 1'b0};
      end
      ebalu_pkg::OP_XOR, ebalu_pkg::OP_OR, ebalu_pkg::OP_SWAP: begin
        if (op_q == ebalu_pkg::OP_XOR) begin
          r8 = a8 ^ b8;
        end else if (op_q == ebalu_pkg::OP_OR) begin
          r8 = a8 | b8;
        end else begin
          r8 = {a8[3:0], a8[7:4]};
        end
        res_d  = {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: 1'b0};
      end
      ebalu_pkg::OP_INC: begin
        r8     = a8 + 8'd1;
        res_d  = {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b0, h: (r8[3:0] == 4'h0), c: fin_q.c};
      end
      ebalu_pkg::OP_DEC: begin
        r8     = a8 - 8'd1;
        res_d  = {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b1, h: (r8[3:0] == 4'hF), c: fin_q.c};
      end
      ebalu_pkg::OP_SLA, ebalu_pkg::OP_RLC, ebalu_pkg::OP_RL: begin
        if (op_q == ebalu_pkg::OP_SLA) begin
          r8 = {a8[6:0], 1'b0};
        end else if (op_q == ebalu_pkg::OP_RLC) begin
          r8 = {a8[6:0], a8[7]};
        end else begin
          r8 = {a8[6:0], fin_q.c};
        end
        res_d  = {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[7]};
      end
      ebalu_pkg::OP_SRA, ebalu_pkg::OP_SRL, ebalu_pkg::OP_RRC, ebalu_pkg::OP_RR: begin
        if (op_q == ebalu_pkg::OP_SRA) begin
          r8 = {a8[7], a8[7:1]};
        end else if (op_q == ebalu_pkg::OP_SRL) begin
          r8 = {1'b0, a8[7:1]};
        end else if (op_q == ebalu_pkg::OP_RRC) begin
          r8 = {a8[0], a8[7:1]};
        end else begin
          r8 = {fin_q.c, a8[7:1]};
        end
        res_d  = {8'd0, r8};
        fout_d = '{z: (r8 == '0), n: 1'b0, h: 1'b0, c: a8[0]};
      end
      ebalu_pkg::OP_BIT: begin
        res_d  = a_q;
        fout_d = '{z: ~a8[bi_q], n: 1'b0, h: 1'b1, c: fin_q.c};
      end
      ebalu_pkg::OP_SET: begin
        r8    = a8 | bit_mask;
        res_d = {8'd0, r8};
      end
      ebalu_pkg::OP_RES: begin
        r8    = a8 & ~bit_mask;
        res_d = {8'd0, r8};
      end
      ebalu_pkg::OP_ADD16: begin
        res_d  = sum17[ebalu_pkg::WordW-1:0];
        fout_d = '{z: fin_q.z, n: 1'b0, h: sum13[12], c: sum17[ebalu_pkg::WordW]};
      end
      ebalu_pkg::OP_ADDSP: begin
        res_d  = sp_sum;
        fout_d = '{z: 1'b0, n: 1'b0, h: sp_nib[4], c: sp_low9[8]};
      end
      default: begin
        // Unused codes pass operand and flags through
        res_d  = a_q;
        fout_d = fin_q;
      end
    endcase
  end

  // Result register and strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      res_q  <= res_d;
      fout_q <= fout_d;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = res_q;
  assign zero_out_o     = fout_q.z;
  assign subtract_out_o = fout_q.n;
  assign half_out_o     = fout_q.h;
  assign carry_out_o    = fout_q.c;

  // Every accepted transaction comes out through the input and result registers
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> ##1 done_o)
    else $error("accepted transaction produced no result");

  // Compare leaves the operand unchanged in the result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && (op_q == ebalu_pkg::OP_CP) |=> result_value_o == $past(a_q))
    else $error("compare changed the result value");

  // Subtract-type operations raise N
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && ((op_q == ebalu_pkg::OP_SUB) || (op_q == ebalu_pkg::OP_SBC) ||
                 (op_q == ebalu_pkg::OP_CP) || (op_q == ebalu_pkg::OP_DEC))
    |=> subtract_out_o)
    else $error("subtract flag missing");

  // Eight-bit logic results and the SLA and RR shift results keep the upper byte clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && ((op_q == ebalu_pkg::OP_AND) || (op_q == ebalu_pkg::OP_XOR) ||
                 (op_q == ebalu_pkg::OP_OR) || (op_q == ebalu_pkg::OP_SWAP) ||
                 (op_q == ebalu_pkg::OP_SLA) || (op_q == ebalu_pkg::OP_RR))
    |=> result_value_o[15:8] == 8'd0)
    else $error("upper byte set on an 8-bit operation");

endmodule
